// File: rtl/stable_priority_queue_unit_defines.svh
// Assertion macros used by the stable priority queue sequencer (spq_seq).
`ifndef STABLE_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Property checked on every rising clk edge, off while arst_n is low.
`define SPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	`SPQ_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: rtl/spq_pkg.sv
// Package: types, codes and defaults of the stable priority queue.
package spq_pkg;

	localparam int CAPACITY_DEF       = 16;
	localparam int VALUE_WIDTH_DEF    = 32;
	localparam int PRIORITY_WIDTH_DEF = 8;

	typedef enum logic [1:0] {
		CMD_ENQ  = 2'd0,
		CMD_DEQ  = 2'd1,
		CMD_LIST = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		status_t status;
		logic    last;
	} res_info_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ENQ_RD,
		S_ENQ_CMP,
		S_ENQ_HEAD,
		S_DEQ_RD,
		S_DEQ_OUT,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_LIST_RD,
		S_LIST_OUT,
		S_RESP
	} state_t;

endpackage

// File: rtl/stable_priority_queue_unit.sv
// Top level: stream ports, sequencer, entry store and output register.
// Enqueue: tail first, each entry is read, then compared; a higher priority value moves it up
// one place, else the new entry is written behind it (at the head past entry 0). Dequeue:
// read, result, then every later entry read and moved down; list: read and result per entry.
// Output register frees the sequencer once a result is handed over; sink stalls add cycles.
// Reset (arst_n low) empties the queue; stored entries are not cleared.
module stable_priority_queue_unit #(
	parameter int CAPACITY       = spq_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH    = spq_pkg::VALUE_WIDTH_DEF,
	parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// in_value, in_priority, zero padding
	input  logic [((VALUE_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	// cmd
	input  logic [1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// out_value, out_priority, zero padding
	output logic [((VALUE_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
	// status
	output logic [1:0] m_tuser,
	output logic m_tlast
);

	localparam int AW     = $clog2(CAPACITY);
	localparam int TDATAW = ((VALUE_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8;

	logic signed [VALUE_WIDTH-1:0] in_value;
	logic [PRIORITY_WIDTH-1:0]     in_priority;

	logic                      res_valid, res_ready;
	spq_pkg::res_info_t        res_info;
	logic [VALUE_WIDTH-1:0]    res_value;
	logic [PRIORITY_WIDTH-1:0] res_priority;

	logic                      wr_en, rd_en;
	logic [AW-1:0]             wr_addr, rd_addr;
	logic [VALUE_WIDTH-1:0]    wr_value, rd_value;
	logic [PRIORITY_WIDTH-1:0] wr_priority, rd_priority;

	logic                      m_tvalid_q;
	spq_pkg::res_info_t        out_info_q;
	logic signed [VALUE_WIDTH-1:0] out_value_q;
	logic [PRIORITY_WIDTH-1:0] out_priority_q;

	assign in_value    = s_tdata[VALUE_WIDTH-1:0];
	assign in_priority = s_tdata[VALUE_WIDTH +: PRIORITY_WIDTH];

	spq_seq #(
		.CAPACITY       (CAPACITY),
		.VALUE_WIDTH    (VALUE_WIDTH),
		.PRIORITY_WIDTH (PRIORITY_WIDTH),
		.AW             (AW)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_cmd       (s_tuser),
		.in_value     (in_value),
		.in_priority  (in_priority),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res_info     (res_info),
		.res_value    (res_value),
		.res_priority (res_priority),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_value     (wr_value),
		.wr_priority  (wr_priority),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_value     (rd_value),
		.rd_priority  (rd_priority)
	);

	spq_store #(
		.CAPACITY       (CAPACITY),
		.VALUE_WIDTH    (VALUE_WIDTH),
		.PRIORITY_WIDTH (PRIORITY_WIDTH),
		.AW             (AW)
	) u_store (
		.clk         (clk),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_value    (wr_value),
		.wr_priority (wr_priority),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_value    (rd_value),
		.rd_priority (rd_priority)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_info_q     <= res_info;
			out_value_q    <= res_value;
			out_priority_q <= res_priority;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TDATAW'({out_priority_q, out_value_q});
	assign m_tuser  = out_info_q.status;
	assign m_tlast  = out_info_q.last;

endmodule

// File: rtl/spq_store.sv
// Entry storage: one write port, one registered read port.
module spq_store #(
	parameter int CAPACITY       = spq_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH    = spq_pkg::VALUE_WIDTH_DEF,
	parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF,
	parameter int AW             = $clog2(CAPACITY)
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [VALUE_WIDTH-1:0]    wr_value,
	input  logic [PRIORITY_WIDTH-1:0] wr_priority,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [VALUE_WIDTH-1:0]    rd_value,
	output logic [PRIORITY_WIDTH-1:0] rd_priority
);

	logic [VALUE_WIDTH-1:0]    value_mem    [CAPACITY];
	logic [PRIORITY_WIDTH-1:0] priority_mem [CAPACITY];
	logic [VALUE_WIDTH-1:0]    rd_value_q;
	logic [PRIORITY_WIDTH-1:0] rd_priority_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			value_mem[wr_addr]    <= wr_value;
			priority_mem[wr_addr] <= wr_priority;
		end
		if (rd_en) begin
			rd_value_q    <= value_mem[rd_addr];
			rd_priority_q <= priority_mem[rd_addr];
		end
	end

	assign rd_value    = rd_value_q;
	assign rd_priority = rd_priority_q;

endmodule

// File: rtl/spq_seq.sv
// Sequencer: insertion scan, dequeue shift and list walk over the entry store.
`include "stable_priority_queue_unit_defines.svh"

module spq_seq #(
	parameter int CAPACITY       = spq_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH    = spq_pkg::VALUE_WIDTH_DEF,
	parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF,
	parameter int AW             = $clog2(CAPACITY)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                in_cmd,
	input  logic [VALUE_WIDTH-1:0]    in_value,
	input  logic [PRIORITY_WIDTH-1:0] in_priority,
	output logic                      res_valid,
	input  logic                      res_ready,
	output spq_pkg::res_info_t        res_info,
	output logic [VALUE_WIDTH-1:0]    res_value,
	output logic [PRIORITY_WIDTH-1:0] res_priority,
	output logic                      wr_en,
	output logic [AW-1:0]             wr_addr,
	output logic [VALUE_WIDTH-1:0]    wr_value,
	output logic [PRIORITY_WIDTH-1:0] wr_priority,
	output logic                      rd_en,
	output logic [AW-1:0]             rd_addr,
	input  logic [VALUE_WIDTH-1:0]    rd_value,
	input  logic [PRIORITY_WIDTH-1:0] rd_priority
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

	spq_pkg::state_t  state_q, state_d;
	spq_pkg::status_t status_q, status_d;
	logic [AW-1:0]    idx_q, idx_d;
	logic [CW-1:0]    count_q, count_d;
	logic             load_in;
	logic [VALUE_WIDTH-1:0]    val_q;
	logic [PRIORITY_WIDTH-1:0] pri_q;
	logic [CW-1:0]    count_m1;
	logic             idx_at_tail;
	logic             enq_on_full;
	logic             res_stall;

	assign count_m1    = count_q - CW'(1);
	assign idx_at_tail = (CW'(idx_q) == count_m1);
	assign enq_on_full = in_valid && in_ready && (in_cmd == spq_pkg::CMD_ENQ)
		&& (count_q == CAP_CNT);
	assign res_stall   = res_valid && !res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= spq_pkg::S_IDLE;
			status_q <= spq_pkg::ST_OK;
			idx_q    <= '0;
			count_q  <= '0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			idx_q    <= idx_d;
			count_q  <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_in) begin
			val_q <= in_value;
			pri_q <= in_priority;
		end
	end

	always_comb begin
		state_d      = state_q;
		status_d     = status_q;
		idx_d        = idx_q;
		count_d      = count_q;
		load_in      = 1'b0;
		in_ready     = 1'b0;
		res_valid    = 1'b0;
		res_info     = '{status: spq_pkg::ST_OK, last: 1'b1};
		res_value    = '0;
		res_priority = '0;
		wr_en        = 1'b0;
		wr_addr      = idx_q;
		wr_value     = val_q;
		wr_priority  = pri_q;
		rd_en        = 1'b0;
		rd_addr      = idx_q;
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					load_in = 1'b1;
					unique case (in_cmd)
						spq_pkg::CMD_ENQ: begin
							if (count_q == CAP_CNT) begin
								status_d = spq_pkg::ST_FULL;
								state_d  = spq_pkg::S_RESP;
							end else if (count_q == '0) begin
								state_d = spq_pkg::S_ENQ_HEAD;
							end else begin
								idx_d   = AW'(count_m1);
								state_d = spq_pkg::S_ENQ_RD;
							end
						end
						spq_pkg::CMD_DEQ: begin
							idx_d = '0;
							if (count_q == '0) begin
								status_d = spq_pkg::ST_EMPTY;
								state_d  = spq_pkg::S_RESP;
							end else begin
								state_d = spq_pkg::S_DEQ_RD;
							end
						end
						spq_pkg::CMD_LIST: begin
							idx_d = '0;
							if (count_q == '0) begin
								status_d = spq_pkg::ST_EMPTY;
								state_d  = spq_pkg::S_RESP;
							end else begin
								state_d = spq_pkg::S_LIST_RD;
							end
						end
						default: state_d = spq_pkg::S_IDLE;
					endcase
				end
			end
			spq_pkg::S_ENQ_RD: begin
				rd_en   = 1'b1;
				state_d = spq_pkg::S_ENQ_CMP;
			end
			spq_pkg::S_ENQ_CMP: begin
				wr_en   = 1'b1;
				wr_addr = idx_q + AW'(1);
				if (rd_priority > pri_q) begin
					wr_value    = rd_value;
					wr_priority = rd_priority;
					if (idx_q == '0) begin
						state_d = spq_pkg::S_ENQ_HEAD;
					end else begin
						idx_d   = idx_q - AW'(1);
						state_d = spq_pkg::S_ENQ_RD;
					end
				end else begin
					count_d  = count_q + CW'(1);
					status_d = spq_pkg::ST_OK;
					state_d  = spq_pkg::S_RESP;
				end
			end
			spq_pkg::S_ENQ_HEAD: begin
				wr_en    = 1'b1;
				wr_addr  = '0;
				count_d  = count_q + CW'(1);
				status_d = spq_pkg::ST_OK;
				state_d  = spq_pkg::S_RESP;
			end
			spq_pkg::S_DEQ_RD: begin
				rd_en   = 1'b1;
				state_d = spq_pkg::S_DEQ_OUT;
			end
			spq_pkg::S_DEQ_OUT: begin
				res_valid    = 1'b1;
				res_value    = rd_value;
				res_priority = rd_priority;
				if (res_ready) begin
					if (count_q == CW'(1)) begin
						count_d = count_m1;
						state_d = spq_pkg::S_IDLE;
					end else begin
						idx_d   = AW'(1);
						state_d = spq_pkg::S_SHIFT_RD;
					end
				end
			end
			spq_pkg::S_SHIFT_RD: begin
				rd_en   = 1'b1;
				state_d = spq_pkg::S_SHIFT_WR;
			end
			spq_pkg::S_SHIFT_WR: begin
				wr_en       = 1'b1;
				wr_addr     = idx_q - AW'(1);
				wr_value    = rd_value;
				wr_priority = rd_priority;
				if (idx_at_tail) begin
					count_d = count_m1;
					state_d = spq_pkg::S_IDLE;
				end else begin
					idx_d   = idx_q + AW'(1);
					state_d = spq_pkg::S_SHIFT_RD;
				end
			end
			spq_pkg::S_LIST_RD: begin
				rd_en   = 1'b1;
				state_d = spq_pkg::S_LIST_OUT;
			end
			spq_pkg::S_LIST_OUT: begin
				res_valid     = 1'b1;
				res_info.last = idx_at_tail;
				res_value     = rd_value;
				res_priority  = rd_priority;
				if (res_ready) begin
					if (idx_at_tail) begin
						state_d = spq_pkg::S_IDLE;
					end else begin
						idx_d   = idx_q + AW'(1);
						state_d = spq_pkg::S_LIST_RD;
					end
				end
			end
			spq_pkg::S_RESP: begin
				res_valid       = 1'b1;
				res_info.status = status_q;
				if (res_ready) begin
					state_d = spq_pkg::S_IDLE;
				end
			end
			default: state_d = spq_pkg::S_IDLE;
		endcase
	end

	`SPQ_ASSERT(a_count_bound, count_q <= CAP_CNT, "entry count above capacity")
	`SPQ_ASSERT(a_one_port_op, !(wr_en && rd_en), "store read and write in one cycle")
	`SPQ_ASSERT_NEXT(a_full_drop, enq_on_full, $stable(count_q), "full enqueue changed count")
	`SPQ_ASSERT_NEXT(a_res_hold, res_stall, res_valid && $stable(res_info), "result withdrawn")

endmodule
